/* rtl/core/pid_antiwindup_discretized_macros.svh */
// Assertion macros shared by the PID controller RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PID_ANTIWINDUP_DISCRETIZED_MACROS_SVH
`define PID_ANTIWINDUP_DISCRETIZED_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIDAW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIDAW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pidaw_pkg.sv */
// Package for the discrete PID controller: widths, register indexes, constants,
// fixed-point helpers and shared types. No dependencies.
`timescale 1ns / 1ps

package pidaw_pkg;

    localparam int STATE_W    = 32;
    localparam int IO_W       = 16;
    localparam int MUL_A_W    = 21;
    localparam int PROD_W     = MUL_A_W + STATE_W;
    localparam int WIDE_W     = PROD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COEF_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int DEG_W      = 9;
    localparam int DISC_W     = 2;
    localparam int DEN_W      = 18;
    localparam int NUM_W      = 33;
    localparam int QUOT_W     = 16;
    localparam int DIV_CNT_W  = 5;

    typedef logic signed [STATE_W-1:0] state_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;
    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic signed [IO_W-1:0]    io_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DISC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ICOEF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DCOEF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FCOEF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd6;

    // Discretization codes; the unused code behaves as bilinear.
    localparam logic [DISC_W-1:0] DISC_BILINEAR = 2'd0;
    localparam logic [DISC_W-1:0] DISC_BACKWARD = 2'd1;
    localparam logic [DISC_W-1:0] DISC_FORWARD  = 2'd2;

    // Register reset values.
    localparam logic [DISC_W-1:0]       RST_DISC   = DISC_BILINEAR;
    localparam logic signed [DEG_W-1:0] RST_TARGET = 9'sd0;
    localparam logic [COEF_W-1:0]       RST_GAIN   = 16'd9830;
    localparam logic [COEF_W-1:0]       RST_ICOEF  = 16'd1170;
    localparam logic [COEF_W-1:0]       RST_DCOEF  = 16'd3584;
    localparam logic [COEF_W-1:0]       RST_FCOEF  = 16'd58796;
    localparam logic [LIMIT_W-1:0]      RST_LIMIT  = 15'd24576;

    // Reference: floor((deg*1024 + 4) / 9). The dividend is biased by 9*32768 so it
    // stays positive, then divided by a reciprocal multiply that is exact below 2^21.
    localparam int     DEG_SHIFT   = 10;
    localparam mul_a_t DEG_BIAS    = 21'sd294916;
    localparam state_t RECIP_NINE  = 32'sd932068;
    localparam int     RECIP_SHIFT = 23;
    localparam int     REF_OFFSET  = 32768;

    // Rounding shifts of the individual terms.
    localparam int unsigned D_SHIFT_BILIN = 7;
    localparam int unsigned D_SHIFT       = 8;
    localparam int unsigned I_SHIFT_BILIN = 17;
    localparam int unsigned I_SHIFT       = 16;
    localparam int unsigned F_SHIFT       = 16;
    localparam int unsigned U_SHIFT       = 12;

    // Filter gain denominators: 2^17 + a for bilinear, 2^16 + a for backward.
    localparam logic [DEN_W-1:0] DEN_BILIN = 18'd131072;
    localparam logic [DEN_W-1:0] DEN_BACK  = 18'd65536;

    localparam state_t STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam state_t STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};

    function automatic wide_t wide_s(input state_t s);
        return wide_t'(s);
    endfunction

    function automatic wide_t wide_p(input prod_t p);
        return wide_t'(p);
    endfunction

    function automatic mul_a_t mul_a_u16(input logic [COEF_W-1:0] v);
        return mul_a_t'(v);
    endfunction

    // Clamp a wide value to the signed state range.
    function automatic state_t sat_state(input wide_t x);
        state_t r;
        if (x > wide_s(STATE_MAX))
            r = STATE_MAX;
        else if (x < wide_s(STATE_MIN))
            r = STATE_MIN;
        else
            r = x[STATE_W-1:0];
        return r;
    endfunction

    // Round half up, then drop n fraction bits (floor of an arithmetic shift).
    function automatic wide_t rnd(input wide_t x, input int unsigned n);
        wide_t half;
        half = wide_t'(1) << (n - 1);
        return (x + half) >>> n;
    endfunction

    // Biased dividend for the target-to-volts conversion.
    function automatic mul_a_t deg_to_dividend(input logic signed [DEG_W-1:0] d);
        mul_a_t ext;
        ext = mul_a_t'(d);
        return (ext <<< DEG_SHIFT) + DEG_BIAS;
    endfunction

endpackage

/* rtl/core/pidaw_if.sv */
// Handshake channels of the PID controller: sensor sample in, drive value out.
// Depends on pidaw_pkg for the payload widths.
`timescale 1ns / 1ps

interface pidaw_sample_if;
    logic                   valid;
    logic                   ready;
    logic signed [pidaw_pkg::IO_W-1:0] sensor_volts;

    modport source (output valid, output sensor_volts, input ready);
    modport sink (input valid, input sensor_volts, output ready);
endinterface

interface pidaw_drive_if;
    logic                   valid;
    logic                   ready;
    logic signed [pidaw_pkg::IO_W-1:0] drive_volts;
    logic                   saturated;

    modport source (output valid, output drive_volts, output saturated, input ready);
    modport sink (input valid, input drive_volts, input saturated, output ready);
endinterface

/* rtl/core/pid_antiwindup_discretized.sv */
// The block takes one sample request at a time and is ready again once its result is in
// the output register; the final step waits while that register holds an unaccepted result.
// After a write to the discretization or filter coefficient register, the next request
// first recomputes the filter gain in the bit-serial divider, unless forward is selected.
// The rate is set by the single shared 21x32 multiplier and its sequencer.
// Reset (rst_n, async, active low) restores default registers and zeroes all PID state.
`timescale 1ns / 1ps
`include "pid_antiwindup_discretized_macros.svh"

module pid_antiwindup_discretized (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]      cfg_data,
    pidaw_sample_if.sink                          sample,
    pidaw_drive_if.source                         drive
);

    // Sequencer states. Each multiply loads its operands in one state, the shared
    // multiplier registers the product in the next, and a later state consumes it.
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DIV     = 4'd1;
    localparam logic [3:0] ST_MUL_R   = 4'd2;
    localparam logic [3:0] ST_POST_R  = 4'd3;
    localparam logic [3:0] ST_LOAD_I  = 4'd4;
    localparam logic [3:0] ST_POST_D  = 4'd5;
    localparam logic [3:0] ST_POST_I  = 4'd6;
    localparam logic [3:0] ST_MUL_F   = 4'd7;
    localparam logic [3:0] ST_POST_F  = 4'd8;
    localparam logic [3:0] ST_LOAD_UN = 4'd9;
    localparam logic [3:0] ST_LOAD_UO = 4'd10;
    localparam logic [3:0] ST_POST_UN = 4'd11;
    localparam logic [3:0] ST_FINAL   = 4'd12;

    logic [3:0] state_reg, state_next;

    // Configuration registers.
    logic [pidaw_pkg::DISC_W-1:0]       disc_reg;
    logic signed [pidaw_pkg::DEG_W-1:0] target_reg;
    logic [pidaw_pkg::COEF_W-1:0]       gain_reg;
    logic [pidaw_pkg::COEF_W-1:0]       icoef_reg;
    logic [pidaw_pkg::COEF_W-1:0]       dcoef_reg;
    logic [pidaw_pkg::COEF_W-1:0]       fcoef_reg;
    logic [pidaw_pkg::LIMIT_W-1:0]      limit_reg;

    // Cached filter gain; it is invalidated whenever its inputs are rewritten.
    logic [pidaw_pkg::QUOT_W-1:0]       g_reg, g_next;
    logic                               g_ok_reg;

    // Controller state carried from one sample to the next.
    pidaw_pkg::state_t last_err_reg, integ_reg, last_d_reg, last_f_reg;

    // Per-sample working registers.
    pidaw_pkg::io_t    sensor_reg, sensor_next;
    pidaw_pkg::mul_a_t a_reg, a_next;
    pidaw_pkg::state_t b_reg, b_next;
    pidaw_pkg::prod_t  prod_reg;
    pidaw_pkg::state_t err_reg, err_next;
    pidaw_pkg::state_t d_reg, d_next;
    pidaw_pkg::state_t inew_reg, inew_next;
    pidaw_pkg::state_t f_reg, f_next;
    logic                          over_reg, over_next;
    pidaw_pkg::io_t    unew_reg, unew_next;

    // Output register.
    logic              out_valid_reg;
    pidaw_pkg::io_t    out_drive_reg, out_drive_next;
    logic              out_sat_reg, out_sat_next;

    logic                           accept;
    logic                           slot_free;
    logic                           finish;
    logic                           is_bilin;
    logic                           is_back;
    logic                           is_fwd;
    logic                           need_div;
    logic                           div_start;
    logic [pidaw_pkg::DEN_W-1:0]    den_sel;
    logic [pidaw_pkg::NUM_W-1:0]    num_sel;
    pidaw_pkg::div_stat_t           div_stat;
    logic [pidaw_pkg::QUOT_W-1:0]   div_quot;

    pidaw_pkg::wide_t  prod_w;
    pidaw_pkg::wide_t  lim_w;
    pidaw_pkg::wide_t  ref_w;
    pidaw_pkg::state_t e_calc;
    pidaw_pkg::state_t de_calc;
    pidaw_pkg::state_t xi_calc;
    pidaw_pkg::state_t d_calc;
    pidaw_pkg::state_t inew_calc;
    pidaw_pkg::state_t xf_calc;
    pidaw_pkg::state_t f_calc;
    pidaw_pkg::wide_t  u_calc;
    pidaw_pkg::io_t    lim16;
    pidaw_pkg::io_t    uclamp_calc;

    // Handshake. The block takes one sample at a time; a finished result waits in
    // the output register, so a new sample can be accepted while it is pending.
    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign slot_free    = !out_valid_reg || drive.ready;
    assign finish       = (state_reg == ST_FINAL) && slot_free;

    assign drive.valid       = out_valid_reg;
    assign drive.drive_volts = out_drive_reg;
    assign drive.saturated   = out_sat_reg;

    // Discretization decode; the spare code falls back to bilinear.
    assign is_back  = (disc_reg == pidaw_pkg::DISC_BACKWARD);
    assign is_fwd   = (disc_reg == pidaw_pkg::DISC_FORWARD);
    assign is_bilin = !is_back && !is_fwd;

    // Filter gain g = round(a * 2^16 / den), worked out by the divider only when the
    // cached value is stale and the selected method uses it.
    assign need_div  = !g_ok_reg && !is_fwd;
    assign div_start = accept && need_div;
    assign den_sel   = (is_bilin ? pidaw_pkg::DEN_BILIN : pidaw_pkg::DEN_BACK)
                       + pidaw_pkg::DEN_W'(fcoef_reg);
    assign num_sel   = {1'b0, fcoef_reg, {pidaw_pkg::QUOT_W{1'b0}}}
                       + pidaw_pkg::NUM_W'(den_sel[pidaw_pkg::DEN_W-1:1]);

    pidaw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_sel),
        .den   (den_sel),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // The shared multiplier runs every cycle on whatever operands are loaded.
    always_ff @(posedge clk)
    begin
        prod_reg <= a_reg * b_reg;
    end

    assign prod_w = pidaw_pkg::wide_p(prod_reg);
    assign lim_w  = pidaw_pkg::wide_t'({1'b0, limit_reg});
    assign lim16  = pidaw_pkg::io_t'({1'b0, limit_reg});

    // Reference voltage from the reciprocal product, then the error and its change.
    assign ref_w   = (prod_w >>> pidaw_pkg::RECIP_SHIFT)
                     - pidaw_pkg::wide_t'(pidaw_pkg::REF_OFFSET);
    assign e_calc  = pidaw_pkg::sat_state(ref_w
                     - pidaw_pkg::wide_s(pidaw_pkg::state_t'(sensor_reg)));
    assign de_calc = pidaw_pkg::sat_state(pidaw_pkg::wide_s(e_calc)
                     - pidaw_pkg::wide_s(last_err_reg));

    // Integrator input: trapezoid of both errors, the new error, or the old error.
    always_comb
    begin
        if (is_back)
            xi_calc = err_reg;
        else if (is_fwd)
            xi_calc = last_err_reg;
        else
            xi_calc = pidaw_pkg::sat_state(pidaw_pkg::wide_s(err_reg)
                      + pidaw_pkg::wide_s(last_err_reg));
    end

    // Raw derivative. Bilinear doubles the gain and subtracts the previous value.
    always_comb
    begin
        if (is_bilin)
            d_calc = pidaw_pkg::sat_state(pidaw_pkg::rnd(prod_w, pidaw_pkg::D_SHIFT_BILIN)
                     - pidaw_pkg::wide_s(last_d_reg));
        else
            d_calc = pidaw_pkg::sat_state(pidaw_pkg::rnd(prod_w, pidaw_pkg::D_SHIFT));
    end

    assign inew_calc = pidaw_pkg::sat_state(pidaw_pkg::wide_s(integ_reg)
                       + pidaw_pkg::rnd(prod_w, is_bilin ? pidaw_pkg::I_SHIFT_BILIN
                                                         : pidaw_pkg::I_SHIFT));

    // Low-pass filter input, relative to the previous filtered derivative.
    always_comb
    begin
        if (is_back)
            xf_calc = pidaw_pkg::sat_state(pidaw_pkg::wide_s(d_reg)
                      - pidaw_pkg::wide_s(last_f_reg));
        else if (is_fwd)
            xf_calc = pidaw_pkg::sat_state(pidaw_pkg::wide_s(last_d_reg)
                      - pidaw_pkg::wide_s(last_f_reg));
        else
            xf_calc = pidaw_pkg::sat_state(pidaw_pkg::wide_s(d_reg)
                      + pidaw_pkg::wide_s(last_d_reg)
                      - (pidaw_pkg::wide_s(last_f_reg) <<< 1));
    end

    assign f_calc = pidaw_pkg::sat_state(pidaw_pkg::wide_s(last_f_reg)
                    + pidaw_pkg::rnd(prod_w, pidaw_pkg::F_SHIFT));

    // Drive value from the current product; used for both the trial and the held pass.
    assign u_calc = pidaw_pkg::rnd(prod_w, pidaw_pkg::U_SHIFT);

    always_comb
    begin
        if (u_calc > lim_w)
            uclamp_calc = lim16;
        else if (u_calc < -lim_w)
            uclamp_calc = -lim16;
        else
            uclamp_calc = u_calc[pidaw_pkg::IO_W-1:0];
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = need_div ? ST_DIV : ST_MUL_R;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_MUL_R;
            end
            ST_MUL_R:   state_next = ST_POST_R;
            ST_POST_R:  state_next = ST_LOAD_I;
            ST_LOAD_I:  state_next = ST_POST_D;
            ST_POST_D:  state_next = ST_POST_I;
            ST_POST_I:  state_next = ST_MUL_F;
            ST_MUL_F:   state_next = ST_POST_F;
            ST_POST_F:  state_next = ST_LOAD_UN;
            ST_LOAD_UN: state_next = ST_LOAD_UO;
            ST_LOAD_UO: state_next = ST_POST_UN;
            ST_POST_UN: state_next = ST_FINAL;
            ST_FINAL:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath loads per sequencer step.
    always_comb
    begin
        sensor_next    = sensor_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        err_next       = err_reg;
        d_next         = d_reg;
        inew_next      = inew_reg;
        f_next         = f_reg;
        over_next      = over_reg;
        unew_next      = unew_reg;
        out_drive_next = out_drive_reg;
        out_sat_next   = out_sat_reg;
        g_next         = div_stat.done ? div_quot : g_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sensor_next = sample.sensor_volts;
                    a_next      = pidaw_pkg::deg_to_dividend(target_reg);
                    b_next      = pidaw_pkg::RECIP_NINE;
                end
            end
            ST_POST_R:
            begin
                err_next = e_calc;
                a_next   = pidaw_pkg::mul_a_u16(dcoef_reg);
                b_next   = de_calc;
            end
            ST_LOAD_I:
            begin
                a_next = pidaw_pkg::mul_a_u16(icoef_reg);
                b_next = xi_calc;
            end
            ST_POST_D:
            begin
                d_next = d_calc;
            end
            ST_POST_I:
            begin
                inew_next = inew_calc;
                a_next    = pidaw_pkg::mul_a_u16(is_fwd ? fcoef_reg : g_reg);
                b_next    = xf_calc;
            end
            ST_POST_F:
            begin
                f_next = f_calc;
            end
            ST_LOAD_UN:
            begin
                a_next = pidaw_pkg::mul_a_u16(gain_reg);
                b_next = pidaw_pkg::sat_state(pidaw_pkg::wide_s(err_reg)
                         + pidaw_pkg::wide_s(inew_reg) + pidaw_pkg::wide_s(f_reg));
            end
            ST_LOAD_UO:
            begin
                a_next = pidaw_pkg::mul_a_u16(gain_reg);
                b_next = pidaw_pkg::sat_state(pidaw_pkg::wide_s(err_reg)
                         + pidaw_pkg::wide_s(integ_reg) + pidaw_pkg::wide_s(f_reg));
            end
            ST_POST_UN:
            begin
                over_next = (u_calc > lim_w) || (u_calc < -lim_w);
                unew_next = u_calc[pidaw_pkg::IO_W-1:0];
            end
            ST_FINAL:
            begin
                // When the trial drive is over the limit the held-integrator drive,
                // still in the multiplier, is clamped and reported instead.
                if (slot_free)
                begin
                    out_drive_next = over_reg ? uclamp_calc : unew_reg;
                    out_sat_next   = over_reg;
                end
            end
            default:
            begin
                sensor_next = sensor_reg;
            end
        endcase
    end

    // Control state, configuration and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            g_ok_reg      <= 1'b0;
            disc_reg      <= pidaw_pkg::RST_DISC;
            target_reg    <= pidaw_pkg::RST_TARGET;
            gain_reg      <= pidaw_pkg::RST_GAIN;
            icoef_reg     <= pidaw_pkg::RST_ICOEF;
            dcoef_reg     <= pidaw_pkg::RST_DCOEF;
            fcoef_reg     <= pidaw_pkg::RST_FCOEF;
            limit_reg     <= pidaw_pkg::RST_LIMIT;
            last_err_reg  <= '0;
            integ_reg     <= '0;
            last_d_reg    <= '0;
            last_f_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (finish)
                out_valid_reg <= 1'b1;
            else if (drive.ready)
                out_valid_reg <= 1'b0;

            if (finish)
            begin
                last_err_reg <= err_reg;
                last_d_reg   <= d_reg;
                last_f_reg   <= f_reg;
                if (!over_reg)
                    integ_reg <= inew_reg;
            end

            // A register write wins over a divider completing in the same cycle.
            if (cfg_we && (cfg_index == pidaw_pkg::CFG_DISC
                           || cfg_index == pidaw_pkg::CFG_FCOEF))
                g_ok_reg <= 1'b0;
            else if (div_stat.done)
                g_ok_reg <= 1'b1;

            if (cfg_we)
            begin
                case (cfg_index)
                    pidaw_pkg::CFG_DISC:   disc_reg   <= cfg_data[pidaw_pkg::DISC_W-1:0];
                    pidaw_pkg::CFG_TARGET: target_reg <= cfg_data[pidaw_pkg::DEG_W-1:0];
                    pidaw_pkg::CFG_GAIN:   gain_reg   <= cfg_data[pidaw_pkg::COEF_W-1:0];
                    pidaw_pkg::CFG_ICOEF:  icoef_reg  <= cfg_data[pidaw_pkg::COEF_W-1:0];
                    pidaw_pkg::CFG_DCOEF:  dcoef_reg  <= cfg_data[pidaw_pkg::COEF_W-1:0];
                    pidaw_pkg::CFG_FCOEF:  fcoef_reg  <= cfg_data[pidaw_pkg::COEF_W-1:0];
                    pidaw_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[pidaw_pkg::LIMIT_W-1:0];
                    default:               limit_reg  <= limit_reg;
                endcase
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        sensor_reg    <= sensor_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        err_reg       <= err_next;
        d_reg         <= d_next;
        inew_reg      <= inew_next;
        f_reg         <= f_next;
        over_reg      <= over_next;
        unew_reg      <= unew_next;
        out_drive_reg <= out_drive_next;
        out_sat_reg   <= out_sat_next;
        g_reg         <= g_next;
    end

    `PIDAW_ASSERT_NEXT(a_busy_after_request, sample.valid && sample.ready, !sample.ready,
        "block still ready after taking a request")
    `PIDAW_ASSERT_SAME(a_result_from_final, $rose(drive.valid), $past(state_reg == ST_FINAL),
        "result appeared outside the final step")
    `PIDAW_ASSERT_NEXT(a_gain_invalidated,
        cfg_we && (cfg_index == pidaw_pkg::CFG_DISC || cfg_index == pidaw_pkg::CFG_FCOEF),
        !g_ok_reg, "filter gain kept after its inputs changed")

endmodule

/* rtl/core/pidaw_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, for the filter gain.
// Depends on pidaw_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "pid_antiwindup_discretized_macros.svh"

module pidaw_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pidaw_pkg::NUM_W-1:0]      num,
    input  logic [pidaw_pkg::DEN_W-1:0]      den,
    output pidaw_pkg::div_stat_t             stat,
    output logic [pidaw_pkg::QUOT_W-1:0]     quot
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [pidaw_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [pidaw_pkg::DEN_W-1:0]       rem_reg, rem_next;
    logic [pidaw_pkg::DEN_W-1:0]       den_reg, den_next;
    logic [pidaw_pkg::QUOT_W-1:0]      sh_reg, sh_next;

    logic [pidaw_pkg::DEN_W:0]         trial;
    logic [pidaw_pkg::DEN_W:0]         diff;
    logic                              fits;

    // The caller guarantees num < den * 2^QUOT_W, so the quotient fits.
    assign trial = {rem_reg, sh_reg[pidaw_pkg::QUOT_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = pidaw_pkg::DIV_CNT_W'(pidaw_pkg::QUOT_W);
            rem_next  = pidaw_pkg::DEN_W'(num[pidaw_pkg::NUM_W-1:pidaw_pkg::QUOT_W]);
            den_next  = den;
            sh_next   = num[pidaw_pkg::QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[pidaw_pkg::DEN_W-1:0] : trial[pidaw_pkg::DEN_W-1:0];
            sh_next  = {sh_reg[pidaw_pkg::QUOT_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pidaw_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = sh_reg;

    `PIDAW_ASSERT_SAME(a_div_rem_below_den, busy_reg, rem_reg < den_reg, "divider remainder overflow")
    `PIDAW_ASSERT_NEXT(a_div_start_busy, start, busy_reg, "divider did not start")
    `PIDAW_ASSERT_NEXT(a_div_last_done, busy_reg && !start && cnt_reg == pidaw_pkg::DIV_CNT_W'(1),
        done_reg && !busy_reg, "divider did not finish")

endmodule
